// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pcr_pkg.sv -----
// Types and constants of the Philox-4x32 generator.
`default_nettype none

package pcr_pkg;

  localparam logic [31:0] MUL_A  = 32'hD2511F53;
  localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
  localparam logic [31:0] WEYL_A = 32'h9E3779B9;
  localparam logic [31:0] WEYL_B = 32'hBB67AE85;

  localparam int unsigned BLK_W  = 30;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned BASE_W = 64;

  typedef enum logic [1:0] {
    REG_KEY_LOW      = 2'd0,
    REG_KEY_HIGH     = 2'd1,
    REG_COUNTER_BASE = 2'd2,
    REG_WORD_LIMIT   = 2'd3
  } cfg_reg_t;

  // Counter words in flight plus the count of in-range words.
  typedef struct packed {
    logic [WORD_W-1:0] x0;
    logic [WORD_W-1:0] x1;
    logic [WORD_W-1:0] x2;
    logic [WORD_W-1:0] x3;
    logic [CNT_W-1:0]  valid_words;
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pcr_channels.sv -----
// Handshake channels of the generator: block index in, random words out, register writes.
`default_nettype none

interface pcr_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcr_pkg::BLK_W-1:0]     block_index;

  modport source (output valid, output block_index, input ready);
  modport sink   (input valid, input block_index, output ready);
endinterface

interface pcr_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcr_pkg::WORD_W-1:0]    word_zero;
  logic [pcr_pkg::WORD_W-1:0]    word_one;
  logic [pcr_pkg::WORD_W-1:0]    word_two;
  logic [pcr_pkg::WORD_W-1:0]    word_three;
  logic [pcr_pkg::CNT_W-1:0]     valid_words;

  modport source (output valid, output word_zero, output word_one, output word_two,
                  output word_three, output valid_words, input ready);
  modport sink   (input valid, input word_zero, input word_one, input word_two,
                  input word_three, input valid_words, output ready);
endinterface

interface pcr_cfg_if;
  logic                          valid;
  logic                          ready;
  pcr_pkg::cfg_reg_t             index;
  logic [pcr_pkg::BASE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/philox_counter_rng_unit.sv -----
// Philox-4x32 counter-based generator: one block index in, four random words out.
// Usage:
//   in_ch  : block index b; the counter is counter_base + b modulo 2^64.
//   out_ch : final counter words zero to three and valid_words, the number of
//            word indices 4b..4b+3 that lie below word_limit.
//   cfg_ch : register writes, always ready; index 0 key_low, 1 key_high,
//            2 counter_base, 3 word_limit. Write only while the pipeline is empty.
// Pipeline: an accepted block reaches out_ch through
//   ROUNDS+1 register stages: the first forms the counter and the valid count,
//   then one stage per round, each holding one pair of 32x32 multipliers.
// Throughput: one block per cycle unless out_ch stalls, with multipliers in every round.
// Reset clears the configuration registers and the stage valid bits, which
//   empties the pipeline.
// A stalled receiver holds the last stage; earlier stages keep filling until
//   they meet a full stage, so empty slots close up and nothing is lost or
//   repeated. in_ch.ready drops only when every stage holds a word and
//   out_ch.ready is low.
`default_nettype none
`include "assert_macros.svh"

module philox_counter_rng_unit #(
  parameter int unsigned ROUNDS = 10
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pcr_in_if.sink      in_ch,
  pcr_out_if.source   out_ch,
  pcr_cfg_if.sink     cfg_ch
);

  localparam int unsigned W = pcr_pkg::WORD_W;

  // Configuration registers.
  logic [W-1:0]                 key_low_r;
  logic [W-1:0]                 key_high_r;
  logic [pcr_pkg::BASE_W-1:0]   counter_base_r;
  logic [W-1:0]                 word_limit_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r      <= '0;
      key_high_r     <= '0;
      counter_base_r <= '0;
      word_limit_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        pcr_pkg::REG_KEY_LOW:      key_low_r      <= cfg_ch.data[W-1:0];
        pcr_pkg::REG_KEY_HIGH:     key_high_r     <= cfg_ch.data[W-1:0];
        pcr_pkg::REG_COUNTER_BASE: counter_base_r <= cfg_ch.data;
        pcr_pkg::REG_WORD_LIMIT:   word_limit_r   <= cfg_ch.data[W-1:0];
        default: ;
      endcase
    end
  end

  // Stage chain: index 0 is the counter stage, 1..ROUNDS are rounds.
  logic            stg_vld [ROUNDS+1];
  pcr_pkg::state_t stg_dat [ROUNDS+1];
  logic            adv     [ROUNDS+1];

  assign adv[ROUNDS] = !stg_vld[ROUNDS] || out_ch.ready;

  genvar gi;
  generate
    for (gi = 0; gi < ROUNDS; gi++) begin : g_adv
      assign adv[gi] = !stg_vld[gi] || adv[gi+1];
    end
  endgenerate

  assign in_ch.ready = adv[0];

  // Counter stage.
  logic                        s0_vld_r;
  pcr_pkg::state_t             s0_dat_r;
  pcr_pkg::state_t             s0_dat_nxt;
  logic [pcr_pkg::BASE_W-1:0]  ctr;
  logic [W-1:0]                first;
  logic [W-1:0]                room;
  logic                        in_acc;

  assign in_acc = in_ch.valid && adv[0];

  always_comb begin
    ctr   = counter_base_r + pcr_pkg::BASE_W'(in_ch.block_index);
    first = {in_ch.block_index, 2'b00};
    room  = word_limit_r - first;
    s0_dat_nxt.x0 = ctr[W-1:0];
    s0_dat_nxt.x1 = ctr[2*W-1:W];
    s0_dat_nxt.x2 = '0;
    s0_dat_nxt.x3 = '0;
    // Count words 4b..4b+3 below the limit; 4b+3 never wraps.
    priority if (word_limit_r <= first) begin
      s0_dat_nxt.valid_words = 3'd0;
    end else if (room > W'(3)) begin
      s0_dat_nxt.valid_words = 3'd4;
    end else begin
      s0_dat_nxt.valid_words = room[pcr_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv[0]) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_dat_r <= s0_dat_nxt;
    end
  end

  assign stg_vld[0] = s0_vld_r;
  assign stg_dat[0] = s0_dat_r;

  generate
    for (gi = 1; gi <= ROUNDS; gi++) begin : g_round
      pcr_round #(
        .ROUND (gi - 1)
      ) u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv[gi]),
        .vld_in   (stg_vld[gi-1]),
        .dat_in   (stg_dat[gi-1]),
        .key_low  (key_low_r),
        .key_high (key_high_r),
        .vld_r    (stg_vld[gi]),
        .dat_r    (stg_dat[gi])
      );
    end
  endgenerate

  assign out_ch.valid       = stg_vld[ROUNDS];
  assign out_ch.word_zero   = stg_dat[ROUNDS].x0;
  assign out_ch.word_one    = stg_dat[ROUNDS].x1;
  assign out_ch.word_two    = stg_dat[ROUNDS].x2;
  assign out_ch.word_three  = stg_dat[ROUNDS].x3;
  assign out_ch.valid_words = stg_dat[ROUNDS].valid_words;

  `PCR_ASSERT_NXT(a_accept_fills, clk, rst_n, in_acc, s0_vld_r, "accepted word not in counter stage")
  `PCR_ASSERT_NXT(a_stage_moves, clk, rst_n, s0_vld_r && adv[1], stg_vld[1], "word lost after counter stage")
  `PCR_ASSERT_IMP(a_count_range, clk, rst_n, out_ch.valid, out_ch.valid_words <= 3'd4, "valid_words above four")

endmodule

`default_nettype wire

// ----- hw/rtl/pcr_round.sv -----
// One registered Philox round: two 32x32 multiplies and the key mix.
`default_nettype none

module pcr_round #(
  parameter int unsigned ROUND = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire logic                       vld_in,
  input  wire pcr_pkg::state_t            dat_in,
  input  wire logic [pcr_pkg::WORD_W-1:0] key_low,
  input  wire logic [pcr_pkg::WORD_W-1:0] key_high,
  output logic                            vld_r,
  output pcr_pkg::state_t                 dat_r
);

  // Weyl offsets for this round, fixed at elaboration.
  localparam logic [63:0] OFS_A = 64'(ROUND) * 64'(pcr_pkg::WEYL_A);
  localparam logic [63:0] OFS_B = 64'(ROUND) * 64'(pcr_pkg::WEYL_B);

  logic [pcr_pkg::WORD_W-1:0]   k0;
  logic [pcr_pkg::WORD_W-1:0]   k1;
  logic [2*pcr_pkg::WORD_W-1:0] pa;
  logic [2*pcr_pkg::WORD_W-1:0] pb;
  pcr_pkg::state_t              dat_nxt;

  always_comb begin
    k0 = key_low + OFS_A[pcr_pkg::WORD_W-1:0];
    k1 = key_high + OFS_B[pcr_pkg::WORD_W-1:0];
    pa = 64'(dat_in.x0) * 64'(pcr_pkg::MUL_A);
    pb = 64'(dat_in.x2) * 64'(pcr_pkg::MUL_B);
    dat_nxt.x0 = pb[63:32] ^ dat_in.x1 ^ k0;
    dat_nxt.x1 = pb[31:0];
    dat_nxt.x2 = pa[63:32] ^ dat_in.x3 ^ k1;
    dat_nxt.x3 = pa[31:0];
    dat_nxt.valid_words = dat_in.valid_words;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load && vld_in) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench of the Philox-4x32 counter generator unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned PHILOX_ROUNDS = 10;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEG_BLOCKS    = 80;

  // Predicts the four words and the in-range count of each accepted block.
  class word_ledger;
    logic [31:0]     key_lo;
    logic [31:0]     key_hi;
    logic [63:0]     base;
    logic [31:0]     word_limit;
    pcr_pkg::state_t pending_words[$];
    int              failures;

    function new();
      key_lo     = '0;
      key_hi     = '0;
      base       = '0;
      word_limit = '0;
      failures   = 0;
    endfunction

    function void set_reg(pcr_pkg::cfg_reg_t idx, logic [63:0] val);
      case (idx)
        pcr_pkg::REG_KEY_LOW:      key_lo     = val[31:0];
        pcr_pkg::REG_KEY_HIGH:     key_hi     = val[31:0];
        pcr_pkg::REG_COUNTER_BASE: base       = val;
        pcr_pkg::REG_WORD_LIMIT:   word_limit = val[31:0];
        default: ;
      endcase
    endfunction

    function pcr_pkg::state_t philox_block(logic [29:0] blk);
      logic [63:0]     ctr;
      logic [63:0]     pa;
      logic [63:0]     pb;
      logic [31:0]     x0, x1, x2, x3, k0, k1;
      logic [32:0]     first;
      logic [2:0]      cnt;
      pcr_pkg::state_t res;
      ctr = base + {34'b0, blk};
      x0  = ctr[31:0];
      x1  = ctr[63:32];
      x2  = '0;
      x3  = '0;
      k0  = key_lo;
      k1  = key_hi;
      for (int r = 0; r < PHILOX_ROUNDS; r++) begin
        if (r > 0) begin
          k0 = k0 + pcr_pkg::WEYL_A;
          k1 = k1 + pcr_pkg::WEYL_B;
        end
        pa = {32'b0, x0} * {32'b0, pcr_pkg::MUL_A};
        pb = {32'b0, x2} * {32'b0, pcr_pkg::MUL_B};
        x0 = pb[63:32] ^ x1 ^ k0;
        x1 = pb[31:0];
        x2 = pa[63:32] ^ x3 ^ k1;
        x3 = pa[31:0];
      end
      // word index 4b+j never exceeds 32 bits; compare with a spare bit anyway
      first = {1'b0, blk, 2'b00};
      cnt   = '0;
      for (int j = 0; j < 4; j++) begin
        if (first + 33'(j) < {1'b0, word_limit}) cnt = cnt + 3'd1;
      end
      res.x0          = x0;
      res.x1          = x1;
      res.x2          = x2;
      res.x3          = x3;
      res.valid_words = cnt;
      return res;
    endfunction

    function void note_block(logic [29:0] blk);
      pending_words.insert(pending_words.size(), philox_block(blk));
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
      end
    endfunction

    function void check_words(pcr_pkg::state_t got);
      pcr_pkg::state_t want;
      if (pending_words.size() == 0) begin
        failures++;
        $display("%0t: unexpected word, actual %08h %08h %08h %08h count %0d", $time,
                 got.x0, got.x1, got.x2, got.x3, got.valid_words);
        return;
      end
      want = pending_words.pop_front();
      cmp_field("word_zero", want.x0, got.x0);
      cmp_field("word_one", want.x1, got.x1);
      cmp_field("word_two", want.x2, got.x2);
      cmp_field("word_three", want.x3, got.x3);
      cmp_field("valid_words", {29'b0, want.valid_words}, {29'b0, got.valid_words});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pcr_in_if  in_ch ();
  pcr_out_if out_ch ();
  pcr_cfg_if cfg_ch ();

  philox_counter_rng_unit #(.ROUNDS(PHILOX_ROUNDS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  word_ledger ledger = new();

  int send_idle;
  int recv_idle;
  int hold_cycles;
  int blocks_sent;
  int settings_used;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // Result side: check each accepted word, then pick the next ready level.
  initial begin
    pcr_pkg::state_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.x0          = out_ch.word_zero;
        got.x1          = out_ch.word_one;
        got.x2          = out_ch.word_two;
        got.x3          = out_ch.word_three;
        got.valid_words = out_ch.valid_words;
        ledger.check_words(got);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  task automatic send_block(logic [29:0] blk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.block_index <= blk;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_block(blk);
    blocks_sent++;
  endtask

  task automatic settle();
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (PHILOX_ROUNDS + 4) @(posedge clk);
  endtask

  task automatic write_reg(pcr_pkg::cfg_reg_t idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    ledger.set_reg(idx, val);
  endtask

  // Drain the pipeline, then load all four registers.
  task automatic apply_settings(logic [63:0] k_lo, logic [63:0] k_hi,
                                logic [63:0] cbase, logic [63:0] limit);
    in_ch.valid <= 1'b0;
    settle();
    write_reg(pcr_pkg::REG_KEY_LOW, k_lo);
    write_reg(pcr_pkg::REG_KEY_HIGH, k_hi);
    write_reg(pcr_pkg::REG_COUNTER_BASE, cbase);
    write_reg(pcr_pkg::REG_WORD_LIMIT, limit);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [29:0] pick_block();
    int unsigned near;
    near = ledger.word_limit >> 2;
    case ($urandom_range(0, 3))
      0:       return 30'($urandom);
      1:       return 30'(near + $urandom_range(0, 4) - 2);
      2:       return 30'($urandom_range(0, 15));
      default: return 30'h3FFF_FFFF - 30'($urandom_range(0, 15));
    endcase
  endfunction

  initial begin
    logic [63:0] limit_val;
    in_ch.valid       <= 1'b0;
    in_ch.block_index <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= pcr_pkg::REG_KEY_LOW;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    send_idle     = 33;
    recv_idle     = 74;
    hold_cycles   = 0;
    blocks_sent   = 0;
    settings_used = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero key, zero base, every word out of range
    send_block(30'd0);
    send_block(30'h3FFF_FFFF);

    // all-ones extremes; base + 1 wraps the counter to zero
    apply_settings('1, '1, '1, '1);
    send_block(30'd0);
    send_block(30'd1);
    send_block(30'h3FFF_FFFF);
    send_block(30'h2AAA_AAAA);

    // limit cuts the third block in half; base carries into the high half
    apply_settings(64'h1234_5678, 64'h9ABC_DEF0, 64'h0000_0000_FFFF_FFFF, 64'd10);
    send_block(30'd0);
    send_block(30'd1);
    send_block(30'd2);
    send_block(30'd3);

    // word indices around 2^31 compared unsigned
    apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                   64'h8000_0000_0000_0000, 64'h8000_0001);
    send_block(30'h2000_0000);
    send_block(30'h1FFF_FFFF);
    send_block(30'h1555_5555);

    // upper data bits of 32-bit registers are dropped
    apply_settings(64'hFFFF_FFFF_0000_0000, 64'hA5A5_A5A5_0000_0000,
                   64'd0, 64'hFFFF_FFFF_0000_0004);
    send_block(30'd0);
    send_block(30'd1);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle = 33;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      limit_val = {$urandom, $urandom};
      if (seg == 0) begin
        apply_settings('1, '1, '1, '1);
      end else if (seg == 1) begin
        apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                       64'hFFFF_FFFF_FFFF_FF00, limit_val);
      end else if (seg == 3) begin
        apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, 64'($urandom_range(0, 64)));
      end else begin
        apply_settings({$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, limit_val);
      end
      // long output stall with the input kept busy fills the pipeline
      if (seg == 4) hold_cycles = 200;
      for (int n = 0; n < SEG_BLOCKS; n++) send_block(pick_block());
    end

    in_ch.valid <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    settle();

    $display("tb_top: %0d blocks checked across %0d register settings", blocks_sent,
             settings_used);
    $display("tb_top: covered counter wrap, limit edges, masked writes and a stall");
    if (ledger.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pcr_pkg.sv
hw/rtl/pcr_channels.sv
hw/rtl/pcr_round.sv
hw/rtl/philox_counter_rng_unit.sv
verif/tb_top.sv
